>>> design/csse_pkg.sv
package csse_pkg;

  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SIZE_W = 12;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // stencil taps: centre, above, below, left, right
  localparam int NPIX    = 5;
  localparam int PIX_CTR = 0;
  localparam int PIX_UP  = 1;
  localparam int PIX_DN  = 2;
  localparam int PIX_LF  = 3;
  localparam int PIX_RT  = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] SHARP_WEIGHT = 3'd5;
  localparam logic [2:0] EDGE_WEIGHT  = 3'd4;

  // gray = (114*B + 587*G + 299*R) / 1000, divide done as multiply by 2^28/1000 rounded up
  localparam int           GRAY_SUM_W  = 18;
  localparam int           GRAY_PROD_W = 37;
  localparam int           GRAY_SHIFT  = 28;
  localparam logic [9:0]   GRAY_R_WT   = 10'd299;
  localparam logic [9:0]   GRAY_G_WT   = 10'd587;
  localparam logic [9:0]   GRAY_B_WT   = 10'd114;
  localparam logic [18:0]  GRAY_RECIP  = 19'd268436;

  localparam logic              MODE_RST   = 1'b0;
  localparam logic [CH_W-1:0]   THRESH_RST = 8'd128;
  localparam logic [SIZE_W-1:0] SIZE_RST   = 12'd2048;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_THRESH = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } csse_reg_t;

  typedef struct packed {
    logic              mode;
    logic [CH_W-1:0]   threshold;
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              restart;
  } csse_cfg_t;

  typedef struct packed {
    logic [NPIX-1:0][PIX_W-1:0] px;
    logic                       last;
  } csse_win_t;

endpackage

>>> design/cross_stencil_sharpen_edge.sv
// Five-point cross stencil over a raster RGB frame: sharpen (centre weight 5,
// per channel) or edge detect (gray, centre weight 4, then threshold to white
// or black). Borders replicate the nearest edge pixel.
// Request channel: a request is taken when push is high and full is low.
// action 0 pushes one pixel; action 1 drains one result of the last row once
// the frame is in. Pixels pushed during a pending flush, and drains with
// nothing pending, are taken and dropped.
// Result channel: the oldest result sits on the outputs while empty is low and
// leaves when pop is high. frame_last marks the frame's final pixel.
// A pixel of row r yields the result for row r-1; row 0 yields none.
// Path: f1 register, window queue, b1 and b2 stages, then the output register.
// Throughput: one request per cycle while full is low. The line buffers are
// read one column ahead, each through one read and one write port.
// A stalled receiver holds the result; the filter pipe freezes and a 4-entry
// window queue absorbs what is in flight, after which full rises.
// Reset clears counters and registers (threshold 128, size 2048 x 2048); the
// line buffers are not cleared. Writing width or height restarts the frame.
module cross_stencil_sharpen_edge import csse_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              push,
  output logic              full,
  input  logic              action,
  input  logic [CH_W-1:0]   red_in,
  input  logic [CH_W-1:0]   green_in,
  input  logic [CH_W-1:0]   blue_in,
  output logic              empty,
  input  logic              pop,
  output logic [CH_W-1:0]   red_out,
  output logic [CH_W-1:0]   green_out,
  output logic [CH_W-1:0]   blue_out,
  output logic              frame_last
);

  csse_cfg_t         cfg;
  logic              q_wr;
  csse_win_t         q_wdata;
  logic              q_rd;
  csse_win_t         q_rdata;
  logic [QCNT_W-1:0] q_count;
  logic              q_empty;

  csse_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csse_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .action   (action),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .q_count  (q_count),
    .q_wr     (q_wr),
    .q_data   (q_wdata)
  );

  csse_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .count (q_count),
    .empty (q_empty)
  );

  csse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_rd       (q_rd),
    .empty      (empty),
    .pop        (pop),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .frame_last (frame_last)
  );

endmodule

>>> design/csse_regs.sv
module csse_regs import csse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output csse_cfg_t         cfg
);

  logic              mode;
  logic [CH_W-1:0]   threshold;
  logic [SIZE_W-1:0] width;
  logic [SIZE_W-1:0] height;
  logic              wr_en;
  csse_reg_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = csse_reg_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_RST;
      threshold <= THRESH_RST;
      width     <= SIZE_RST;
      height    <= SIZE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_MODE:   mode      <= pwdata[0];
        REG_THRESH: threshold <= pwdata[CH_W-1:0];
        REG_WIDTH:  width     <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height    <= pwdata[SIZE_W-1:0];
        default:    mode      <= mode;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:   prdata = DATA_W'(mode);
      REG_THRESH: prdata = DATA_W'(threshold);
      REG_WIDTH:  prdata = DATA_W'(width);
      REG_HEIGHT: prdata = DATA_W'(height);
      default:    prdata = '0;
    endcase
  end

  // a new frame size restarts the frame
  always_comb begin
    cfg.mode      = mode;
    cfg.threshold = threshold;
    cfg.width     = width;
    cfg.height    = height;
    cfg.restart   = wr_en && (idx == REG_WIDTH || idx == REG_HEIGHT);
  end

endmodule

>>> design/csse_front.sv
module csse_front import csse_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  csse_cfg_t         cfg,
  input  logic              push,
  output logic              full,
  input  logic              action,
  input  logic [CH_W-1:0]   red_in,
  input  logic [CH_W-1:0]   green_in,
  input  logic [CH_W-1:0]   blue_in,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_wr,
  output csse_win_t         q_data
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP = (WW > SIZE_W) ? WW : SIZE_W;
  localparam int HCMP = (HW > SIZE_W) ? HW : SIZE_W;

  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];

  logic [AW-1:0]    col;
  logic [HW-1:0]    row;
  logic [WW-1:0]    pending;
  logic [PIX_W-1:0] left_px;
  logic [PIX_W-1:0] rd_new;
  logic [PIX_W-1:0] rd_old;
  logic             byp_new;
  logic             byp_old;
  logic [PIX_W-1:0] byp_new_px;
  logic [PIX_W-1:0] byp_old_px;

  logic             f1_valid;
  logic [PIX_W-1:0] f1_ctr;
  logic [PIX_W-1:0] f1_up;
  logic [PIX_W-1:0] f1_dn;
  logic [PIX_W-1:0] f1_lf;
  logic             f1_has_rt;
  logic             f1_last;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [PIX_W-1:0] px;
  logic             accept;
  logic             do_push;
  logic             do_drain;
  logic             active;
  logic             emit;
  logic             top;
  logic             has_rt;
  logic             drain_last;
  logic [WW-1:0]    col_inc;
  logic [AW-1:0]    col_next;
  logic [HW-1:0]    row_inc;
  logic             row_wrap;
  logic [PIX_W-1:0] cur_new;
  logic [PIX_W-1:0] cur_old;
  logic [PIX_W-1:0] up_px;
  logic [PIX_W-1:0] dn_px;
  logic [PIX_W-1:0] lf_px;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = WW'(1);
    end else if (WCMP'(cfg.width) > WCMP'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_eff = HW'(1);
    end else if (HCMP'(cfg.height) > HCMP'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg.height);
    end
  end

  assign full     = (q_count + QCNT_W'(f1_valid)) >= QCNT_W'(QUEUE_DEPTH);
  assign px       = {red_in, green_in, blue_in};
  assign accept   = push && !full;
  // pushes wait out a pending flush, drains need something pending; others drop
  assign do_push  = accept && !action && (pending == '0);
  assign do_drain = accept && action && (pending != '0);
  assign active   = do_push || do_drain;

  // prefetched column, with forwarding when the next column is this one
  assign cur_new = byp_new ? byp_new_px : rd_new;
  assign cur_old = byp_old ? byp_old_px : rd_old;

  assign col_inc    = WW'(col) + WW'(1);
  assign has_rt     = col_inc < w_eff;
  assign drain_last = pending == WW'(1);
  assign col_next   = (!has_rt || (do_drain && drain_last)) ? '0 : col_inc[AW-1:0];
  assign row_inc    = row + HW'(1);
  assign row_wrap   = !(row_inc < h_eff);

  assign emit  = do_drain || (do_push && row != '0);
  assign top   = do_push ? (row == HW'(1)) : (h_eff == HW'(1));
  assign up_px = top ? cur_new : cur_old;
  assign dn_px = do_push ? px : cur_new;
  assign lf_px = (col != '0) ? left_px : cur_new;

  always_ff @(posedge clk) begin
    if (active) begin
      older_mem[col] <= cur_new;
      if (do_push) begin
        newer_mem[col] <= px;
      end
      rd_new <= newer_mem[col_next];
      rd_old <= older_mem[col_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp_new <= 1'b0;
      byp_old <= 1'b0;
    end else if (active) begin
      byp_new <= do_push && (col_next == col);
      byp_old <= col_next == col;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      byp_new_px <= px;
      byp_old_px <= cur_new;
      left_px    <= cur_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col     <= '0;
      row     <= '0;
      pending <= '0;
    end else if (do_push) begin
      col <= col_next;
      if (!has_rt) begin
        if (row_wrap) begin
          row     <= '0;
          pending <= w_eff;
        end else begin
          row <= row_inc;
        end
      end
    end else if (do_drain) begin
      col     <= col_next;
      pending <= pending - WW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      f1_ctr    <= cur_new;
      f1_up     <= up_px;
      f1_dn     <= dn_px;
      f1_lf     <= lf_px;
      f1_has_rt <= has_rt;
      f1_last   <= do_drain && drain_last;
    end
  end

  // right neighbor arrives from the read issued with the request
  always_comb begin
    q_wr                = f1_valid;
    q_data.px[PIX_CTR]  = f1_ctr;
    q_data.px[PIX_UP]   = f1_up;
    q_data.px[PIX_DN]   = f1_dn;
    q_data.px[PIX_LF]   = f1_lf;
    q_data.px[PIX_RT]   = f1_has_rt ? cur_new : f1_ctr;
    q_data.last         = f1_last;
  end

  a_flush_in_row0: assert property (@(posedge clk) disable iff (rst)
    (pending != '0) |-> (row == '0))
    else $error("flush pending outside the first row");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    (do_drain && drain_last) |=> (q_wr && q_data.last))
    else $error("final drain did not yield a frame_last result");

endmodule

>>> design/csse_fifo.sv
module csse_fifo import csse_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  csse_win_t         wdata,
  input  logic              rd,
  output csse_win_t         rdata,
  output logic [QCNT_W-1:0] count,
  output logic              empty
);

  csse_win_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;

  assign rdata = entries[rptr];
  assign empty = count == '0;

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (rd) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(wr) - QCNT_W'(rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> (count < QCNT_W'(QUEUE_DEPTH)))
    else $error("window queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> (count != '0))
    else $error("window queue underflow");

endmodule

>>> design/csse_back.sv
module csse_back import csse_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  csse_cfg_t       cfg,
  input  logic            q_empty,
  input  csse_win_t       q_data,
  output logic            q_rd,
  output logic            empty,
  input  logic            pop,
  output logic [CH_W-1:0] red_out,
  output logic [CH_W-1:0] green_out,
  output logic [CH_W-1:0] blue_out,
  output logic            frame_last
);

  function automatic logic [CH_W-1:0] stencil(input logic [2:0] wt,
                                               input logic [NPIX-1:0][CH_W-1:0] v);
    logic [10:0]        pos;
    logic [9:0]         neg;
    logic signed [11:0] s;
    pos = 11'(v[PIX_CTR]) * 11'(wt);
    neg = 10'(v[PIX_UP]) + 10'(v[PIX_DN]) + 10'(v[PIX_LF]) + 10'(v[PIX_RT]);
    s   = $signed({1'b0, pos}) - $signed({2'b00, neg});
    if (s < 12'sd0) begin
      stencil = '0;
    end else if (s > 12'sd255) begin
      stencil = 8'hFF;
    end else begin
      stencil = s[CH_W-1:0];
    end
  endfunction

  logic                   adv;
  logic                   out_v;
  logic                   b1_v;
  csse_win_t              b1_win;
  logic [GRAY_SUM_W-1:0]  b1_sum [NPIX];
  logic                   b2_v;
  csse_win_t              b2_win;
  logic [NPIX-1:0][CH_W-1:0] b2_gray;

  logic [GRAY_SUM_W-1:0]  sum_d  [NPIX];
  logic [GRAY_PROD_W-1:0] prod   [NPIX];
  logic [NPIX-1:0][CH_W-1:0] gray_d;
  logic [NPIX-1:0][CH_W-1:0] red_v;
  logic [NPIX-1:0][CH_W-1:0] green_v;
  logic [NPIX-1:0][CH_W-1:0] blue_v;
  logic [CH_W-1:0]        edge_v;
  logic [CH_W-1:0]        edge_px;

  // advance the whole pipe unless the held result is refused
  assign adv   = !out_v || pop;
  assign q_rd  = adv && !q_empty;
  assign empty = !out_v;

  always_comb begin
    for (int k = 0; k < NPIX; k++) begin
      sum_d[k] = GRAY_SUM_W'(q_data.px[k][2*CH_W +: CH_W]) * GRAY_SUM_W'(GRAY_R_WT)
               + GRAY_SUM_W'(q_data.px[k][CH_W +: CH_W]) * GRAY_SUM_W'(GRAY_G_WT)
               + GRAY_SUM_W'(q_data.px[k][0 +: CH_W]) * GRAY_SUM_W'(GRAY_B_WT);
      prod[k]   = GRAY_PROD_W'(b1_sum[k]) * GRAY_PROD_W'(GRAY_RECIP);
      gray_d[k] = prod[k][GRAY_SHIFT +: CH_W];
      red_v[k]   = b2_win.px[k][2*CH_W +: CH_W];
      green_v[k] = b2_win.px[k][CH_W +: CH_W];
      blue_v[k]  = b2_win.px[k][0 +: CH_W];
    end
  end

  assign edge_v  = stencil(EDGE_WEIGHT, b2_gray);
  assign edge_px = (edge_v > cfg.threshold) ? 8'hFF : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v  <= 1'b0;
      b2_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (adv) begin
      b1_v  <= q_rd;
      b2_v  <= b1_v;
      out_v <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_win  <= q_data;
      b1_sum  <= sum_d;
      b2_win  <= b1_win;
      b2_gray <= gray_d;
      if (cfg.mode) begin
        red_out   <= edge_px;
        green_out <= edge_px;
        blue_out  <= edge_px;
      end else begin
        red_out   <= stencil(SHARP_WEIGHT, red_v);
        green_out <= stencil(SHARP_WEIGHT, green_v);
        blue_out  <= stencil(SHARP_WEIGHT, blue_v);
      end
      frame_last <= b2_win.last;
    end
  end

  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    (out_v && !pop) |=> $stable({b1_v, b2_v}))
    else $error("filter pipe moved while the result was held");

endmodule

>>> bench/cross_stencil_sharpen_edge_tb.sv
module cross_stencil_sharpen_edge_tb;
  import csse_pkg::*;

  localparam int          MAX_W         = 2048;
  localparam int          MAX_H         = 2048;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          CENTRE_SHARP  = 5;
  localparam int          CENTRE_EDGE   = 4;
  localparam logic        ACT_PUSH      = 1'b0;
  localparam logic        ACT_DRAIN     = 1'b1;
  localparam logic [7:0]  WHITE         = 8'hFF;
  localparam logic [7:0]  BLACK         = 8'h00;

  typedef struct packed {
    logic            op;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_req_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } filtered_px_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              push = 1'b0;
  logic              full;
  logic              action = ACT_PUSH;
  logic [CH_W-1:0]   red_in = '0;
  logic [CH_W-1:0]   green_in = '0;
  logic [CH_W-1:0]   blue_in = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [CH_W-1:0]   red_out;
  logic [CH_W-1:0]   green_out;
  logic [CH_W-1:0]   blue_out;
  logic              frame_last;

  cross_stencil_sharpen_edge dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .push       (push),
    .full       (full),
    .action     (action),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .empty      (empty),
    .pop        (pop),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .frame_last (frame_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // filter state mirror
  logic [PIX_W-1:0]  older_row [MAX_W];
  logic [PIX_W-1:0]  newer_row [MAX_W];
  int unsigned       col_at = 0;
  int unsigned       row_at = 0;
  int unsigned       flush_left = 0;
  logic              mode_cfg = 1'b0;
  logic [CH_W-1:0]   thresh_cfg = 8'd128;
  logic [SIZE_W-1:0] width_cfg = 12'd2048;
  logic [SIZE_W-1:0] height_cfg = 12'd2048;

  pixel_req_t   pixel_q[$];
  filtered_px_t filtered_q[$];
  int unsigned  queued_total = 0;
  int unsigned  fail_count = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  bit           req_taken = 1'b0;
  logic [7:0]   tone [3];
  int unsigned  tone_spread = 255;

  function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic int gray_of(logic [PIX_W-1:0] px);
    return (114 * int'(px[7:0]) + 587 * int'(px[15:8]) + 299 * int'(px[23:16])) / 1000;
  endfunction

  function automatic logic [7:0] cross_stencil(int weight, int c, int u, int d, int l, int r);
    int s;
    s = weight * c - u - d - l - r;
    if (s < 0) return 8'd0;
    if (s > 255) return 8'd255;
    return s[7:0];
  endfunction

  // filter column x of the row in newer_row; the row then moves to older_row
  function automatic filtered_px_t filter_at(int unsigned x, int unsigned w, bit top,
                                             logic [PIX_W-1:0] below);
    logic [PIX_W-1:0] c, u, r, l;
    logic [7:0]       v;
    filtered_px_t     res;
    c = newer_row[x];
    u = top ? c : older_row[x];
    r = (x + 1 < w) ? newer_row[x + 1] : c;
    older_row[x] = c;
    l = (x > 0) ? older_row[x - 1] : c;
    res.last = 1'b0;
    if (mode_cfg) begin
      v = cross_stencil(CENTRE_EDGE, gray_of(c), gray_of(u), gray_of(below), gray_of(l),
                        gray_of(r));
      res.red   = (v > thresh_cfg) ? WHITE : BLACK;
      res.green = res.red;
      res.blue  = res.red;
    end else begin
      res.red   = cross_stencil(CENTRE_SHARP, c[23:16], u[23:16], below[23:16], l[23:16],
                                r[23:16]);
      res.green = cross_stencil(CENTRE_SHARP, c[15:8], u[15:8], below[15:8], l[15:8],
                                r[15:8]);
      res.blue  = cross_stencil(CENTRE_SHARP, c[7:0], u[7:0], below[7:0], l[7:0], r[7:0]);
    end
    return res;
  endfunction

  function automatic void filter_request(pixel_req_t rq);
    int unsigned      w, h, x;
    logic [PIX_W-1:0] px;
    filtered_px_t     res;
    w = clamp_size(width_cfg, MAX_W);
    h = clamp_size(height_cfg, MAX_H);
    x = (col_at < w) ? col_at : 0;
    px = {rq.red, rq.green, rq.blue};
    if (rq.op == ACT_PUSH) begin
      // drop pixels while the last row is still flushing
      if (flush_left != 0) return;
      if (row_at >= 1) begin
        res = filter_at(x, w, row_at == 1, px);
        filtered_q.push_back(res);
      end else begin
        older_row[x] = newer_row[x];
      end
      newer_row[x] = px;
      if (x + 1 < w) begin
        col_at = x + 1;
      end else begin
        col_at = 0;
        if (row_at + 1 < h) begin
          row_at++;
        end else begin
          row_at = 0;
          flush_left = w;
        end
      end
    end else if (flush_left != 0) begin
      res = filter_at(x, w, h == 1, newer_row[x]);
      flush_left--;
      res.last = (flush_left == 0);
      filtered_q.push_back(res);
      col_at = (flush_left == 0 || x + 1 >= w) ? 0 : x + 1;
    end
  endfunction

  function automatic void apply_setting(csse_reg_t idx, logic [DATA_W-1:0] value);
    case (idx)
      REG_MODE:   mode_cfg = value[0];
      REG_THRESH: thresh_cfg = value[CH_W-1:0];
      REG_WIDTH, REG_HEIGHT: begin
        if (idx == REG_WIDTH) width_cfg = value[SIZE_W-1:0];
        else height_cfg = value[SIZE_W-1:0];
        // size change restarts the frame
        col_at = 0;
        row_at = 0;
        flush_left = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] reg_mask(csse_reg_t idx);
    case (idx)
      REG_MODE:   return 32'h1;
      REG_THRESH: return 32'hFF;
      default:    return 32'hFFF;
    endcase
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // request side: hold a request until taken
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || req_taken) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        {action, red_in, green_in, blue_in} <= pixel_q[0];
      end else begin
        push <= 1'b0;
      end
    end
    req_taken = 1'b0;
    pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : monitor_blk
    filtered_px_t want;
    if (!rst && push && !full) begin
      filter_request('{action, red_in, green_in, blue_in});
      void'(pixel_q.pop_front());
      req_taken = 1'b1;
    end
    if (!rst && pop && !empty) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d frame_last %0b",
               red_out, green_out, blue_out, frame_last);
        fail_count++;
      end else begin
        want = filtered_q.pop_front();
        check_field("red_out", want.red, red_out);
        check_field("green_out", want.green, green_out);
        check_field("blue_out", want.blue, blue_out);
        check_field("frame_last", 8'(want.last), 8'(frame_last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic check_reg(csse_reg_t idx, logic [DATA_W-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(4 * int'(idx));
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $error("register %s: expected %0d, got %0d", idx.name(), want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(csse_reg_t idx, logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_setting(idx, value);
    check_reg(idx, value & reg_mask(idx));
  endtask

  // wait until every request is taken and every result is back
  task automatic settle(int unsigned tail);
    while (pixel_q.size() != 0 || push || filtered_q.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic queue_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_q.push_back('{ACT_PUSH, r, g, b});
    queued_total++;
  endtask

  task automatic queue_drain();
    pixel_q.push_back('{ACT_DRAIN, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255))});
    queued_total++;
  endtask

  function automatic logic [7:0] near_tone(int ch);
    int v;
    if (tone_spread >= 128) return 8'($urandom_range(255));
    v = int'(tone[ch]) + int'($urandom_range(2 * tone_spread)) - int'(tone_spread);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic queue_tone_pixel();
    queue_pixel(near_tone(0), near_tone(1), near_tone(2));
  endtask

  // one frame; a cut frame stops early and is restarted by the next size write
  task automatic run_frame(int unsigned w, int unsigned h, bit cut);
    int unsigned pixels, pause_at;
    pixels = cut ? $urandom_range(w * h - 1) : w * h;
    pause_at = $urandom_range(w * h - 1);
    for (int unsigned i = 0; i < pixels; i++) begin
      if ($urandom_range(15) == 0) queue_drain();
      if (i == pause_at && $urandom_range(3) == 0) settle(0);
      queue_tone_pixel();
    end
    if (cut) return;
    for (int unsigned i = 0; i < w; i++) begin
      if ($urandom_range(7) == 0) queue_tone_pixel();
      queue_drain();
    end
    if ($urandom_range(3) == 0) queue_drain();
  endtask

  task automatic random_frame();
    logic [SIZE_W-1:0] w_reg, h_reg;
    int unsigned       kind;
    settle(SETTLE_CYCLES);
    if ($urandom_range(2) == 0) write_reg(REG_MODE, $urandom_range(1));
    if ($urandom_range(2) == 0) begin
      kind = $urandom_range(3);
      write_reg(REG_THRESH, (kind == 0) ? 0 : (kind == 1) ? 255 : $urandom_range(255));
    end
    w_reg = ($urandom_range(19) == 0) ? 12'd0 : 12'($urandom_range(1, 12));
    h_reg = ($urandom_range(19) == 0) ? 12'd0 : 12'($urandom_range(1, 5));
    write_reg(REG_WIDTH, w_reg);
    write_reg(REG_HEIGHT, h_reg);
    for (int ch = 0; ch < 3; ch++) tone[ch] = 8'($urandom_range(255));
    kind = $urandom_range(2);
    tone_spread = (kind == 0) ? 3 : (kind == 1) ? 40 : 255;
    repeat ($urandom_range(1, 2)) begin
      run_frame(clamp_size(w_reg, MAX_W), clamp_size(h_reg, MAX_H), $urandom_range(7) == 0);
    end
  endtask

  task automatic random_frames(int unsigned goal);
    int unsigned start;
    start = queued_total;
    while (queued_total - start < goal) random_frame();
  endtask

  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 75;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_reg(REG_MODE, 32'd0);
    check_reg(REG_THRESH, 32'd128);
    check_reg(REG_WIDTH, 32'd2048);
    check_reg(REG_HEIGHT, 32'd2048);

    // drain before any frame: dropped
    queue_drain();
    settle(SETTLE_CYCLES);

    // sharpen, 3 x 2, channel extremes
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_WIDTH, 32'd3);
    write_reg(REG_HEIGHT, 32'd2);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd0, 8'd128);
    queue_pixel(8'd0, 8'd255, 8'd0);
    queue_pixel(8'd128, 8'd128, 8'd128);
    queue_pixel(8'd1, 8'd2, 8'd254);
    queue_pixel(8'd77, 8'd88, 8'd99);
    repeat (3) queue_drain();
    queue_drain();
    settle(SETTLE_CYCLES);

    // edge detect, threshold at its floor
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_THRESH, 32'd0);
    write_reg(REG_WIDTH, 32'd2);
    write_reg(REG_HEIGHT, 32'd2);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    repeat (2) queue_drain();
    settle(SETTLE_CYCLES);

    // zero sizes act as a single pixel; threshold at its ceiling
    write_reg(REG_THRESH, 32'd255);
    write_reg(REG_WIDTH, 32'd0);
    write_reg(REG_HEIGHT, 32'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_drain();

    random_frames(330);
    send_idle_pct = 75;
    recv_idle_pct = 34;
    random_frames(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_frames(330);

    // oversized sizes clamp; a short run stays in the first row
    settle(SETTLE_CYCLES);
    write_reg(REG_MODE, 32'd0);
    write_reg(REG_WIDTH, 32'd4095);
    write_reg(REG_HEIGHT, 32'd4095);
    tone_spread = 255;
    repeat (24) queue_tone_pixel();

    // narrow rows under a clamped height keep giving results
    settle(SETTLE_CYCLES);
    write_reg(REG_MODE, 32'd1);
    write_reg(REG_THRESH, $urandom_range(255));
    write_reg(REG_WIDTH, 32'd5);
    repeat (40) queue_tone_pixel();

    settle(SETTLE_CYCLES);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
design/csse_pkg.sv
design/csse_regs.sv
design/csse_front.sv
design/csse_fifo.sv
design/csse_back.sv
design/cross_stencil_sharpen_edge.sv
bench/cross_stencil_sharpen_edge_tb.sv
